### rtl/obbf_pkg.sv
`default_nettype none

package obbf_pkg;

	localparam int SLOT_W        = 4;
	localparam int SLOT_COUNT    = 14;
	localparam int SLOTS_PER_BOX = 7;

	localparam logic [SLOT_W-1:0] SLOT_A_CENTER = 4'd0;
	localparam logic [SLOT_W-1:0] SLOT_A_AXIS   = 4'd1;
	localparam logic [SLOT_W-1:0] SLOT_A_HALF   = 4'd4;
	localparam logic [SLOT_W-1:0] SLOT_B_CENTER = 4'd7;
	localparam logic [SLOT_W-1:0] SLOT_B_AXIS   = 4'd8;
	localparam logic [SLOT_W-1:0] SLOT_B_HALF   = 4'd11;
	localparam logic [SLOT_W-1:0] LAST_SLOT     = 4'd13;

	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD_CA,
		OP_LOAD_DIFF,
		OP_LOAD_AXIS,
		OP_DOT_FIRST,
		OP_DOT_NEXT,
		OP_DOT_DIFF
	} op_t;

	typedef struct packed {
		logic [SLOT_W-1:0] addr;
		op_t               op;
	} cmd_t;

	typedef struct packed {
		logic act_a;
		logic act_b;
		logic sep;
	} status_t;

endpackage

`default_nettype wire

### rtl/obbf_dp.sv
`default_nettype none

module obbf_dp #(
	parameter int COORD_WIDTH = 24
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          wr_en,
	input  wire logic [obbf_pkg::SLOT_W-1:0]   wr_slot,
	input  wire logic [COORD_WIDTH-1:0]        wr_x,
	input  wire logic [COORD_WIDTH-1:0]        wr_y,
	input  wire logic [COORD_WIDTH-1:0]        wr_z,
	input  wire logic                          wr_active,
	input  wire obbf_pkg::cmd_t                cmd,
	output obbf_pkg::status_t                  status
);

	localparam int CW    = COORD_WIDTH;
	localparam int CW1   = CW + 1;
	localparam int PW    = 2 * CW + 2;
	localparam int DW    = PW + 2;
	localparam int ACC_W = DW + 3;

	logic [3*CW-1:0] mem_q [obbf_pkg::SLOT_COUNT];
	logic [3*CW-1:0] rd_s1;
	obbf_pkg::op_t   op_s1, op_s2, op_s3;

	logic act_a_q, act_b_q, sep_q;

	logic signed [CW-1:0]  ca_q   [3];
	logic signed [CW-1:0]  axis_q [3];
	logic signed [CW1-1:0] diff_q [3];

	logic signed [CW-1:0]  rd_v  [3];
	logic signed [CW1-1:0] opnd  [3];
	logic signed [PW-1:0]  prod_s2 [3];
	logic signed [DW-1:0]  sum_w;
	logic [DW-1:0]         dot_abs;
	logic [DW-1:0]         dot_s3;
	logic [ACC_W-1:0]      lhs_q;

	always_ff @(posedge clk) begin
		if (wr_en && (wr_slot < obbf_pkg::SLOT_W'(obbf_pkg::SLOT_COUNT))) begin
			mem_q[wr_slot] <= {wr_z, wr_y, wr_x};
		end
		rd_s1 <= mem_q[cmd.addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_a_q <= 1'b0;
			act_b_q <= 1'b0;
		end else if (wr_en) begin
			if (wr_slot == obbf_pkg::SLOT_A_CENTER) begin
				act_a_q <= wr_active;
			end
			if (wr_slot == obbf_pkg::SLOT_B_CENTER) begin
				act_b_q <= wr_active;
			end
		end
	end

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rd_v[c] = rd_s1[c*CW +: CW];
			if (op_s1 == obbf_pkg::OP_DOT_DIFF) begin
				opnd[c] = diff_q[c];
			end else begin
				opnd[c] = CW1'(rd_v[c]);
			end
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			case (op_s1)
				obbf_pkg::OP_LOAD_CA: begin
					ca_q[c] <= rd_v[c];
				end
				obbf_pkg::OP_LOAD_DIFF: begin
					diff_q[c] <= CW1'(rd_v[c]) - CW1'(ca_q[c]);
				end
				obbf_pkg::OP_LOAD_AXIS: begin
					axis_q[c] <= rd_v[c];
				end
				default: begin
				end
			endcase
			prod_s2[c] <= PW'(axis_q[c]) * PW'(opnd[c]);
		end
	end

	always_comb begin
		sum_w   = DW'(prod_s2[0]) + DW'(prod_s2[1]) + DW'(prod_s2[2]);
		dot_abs = sum_w[DW-1] ? DW'(-sum_w) : DW'(sum_w);
	end

	always_ff @(posedge clk) begin
		dot_s3 <= dot_abs;
		case (op_s3)
			obbf_pkg::OP_DOT_FIRST: lhs_q <= ACC_W'(dot_s3);
			obbf_pkg::OP_DOT_NEXT:  lhs_q <= lhs_q + ACC_W'(dot_s3);
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_s1 <= obbf_pkg::OP_NONE;
			op_s2 <= obbf_pkg::OP_NONE;
			op_s3 <= obbf_pkg::OP_NONE;
			sep_q <= 1'b0;
		end else begin
			op_s1 <= cmd.op;
			op_s2 <= op_s1;
			op_s3 <= op_s2;
			if (op_s1 == obbf_pkg::OP_LOAD_CA) begin
				sep_q <= 1'b0;
			end else if ((op_s3 == obbf_pkg::OP_DOT_DIFF) && (lhs_q < ACC_W'(dot_s3))) begin
				sep_q <= 1'b1;
			end
		end
	end

	assign status.act_a = act_a_q;
	assign status.act_b = act_b_q;
	assign status.sep   = sep_q;

endmodule

`default_nettype wire

### rtl/obbf_ctrl.sv
`default_nettype none

module obbf_ctrl (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [obbf_pkg::SLOT_W-1:0] slot,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             hit,
	output obbf_pkg::cmd_t                   cmd,
	input  wire obbf_pkg::status_t           status
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CENTER_A,
		ST_CENTER_B,
		ST_AXIS,
		ST_DOT,
		ST_DIFF,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	localparam logic [1:0] IDX_LAST   = 2'd2;
	localparam logic [1:0] DRAIN_LAST = 2'd3;

	state_t         state_q;
	obbf_pkg::cmd_t cmd_q;
	logic           out_valid_q, hit_q;
	logic           ax_box_q, h_box_q;
	logic [1:0]     ax_idx_q, h_idx_q, drain_q;

	logic [obbf_pkg::SLOT_W-1:0] axis_addr, half_addr;

	always_comb begin
		axis_addr = (ax_box_q ? obbf_pkg::SLOT_B_AXIS : obbf_pkg::SLOT_A_AXIS)
			+ obbf_pkg::SLOT_W'(ax_idx_q);
		half_addr = (h_box_q ? obbf_pkg::SLOT_B_HALF : obbf_pkg::SLOT_A_HALF)
			+ obbf_pkg::SLOT_W'(h_idx_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cmd_q       <= '{addr: '0, op: obbf_pkg::OP_NONE};
			out_valid_q <= 1'b0;
			hit_q       <= 1'b0;
			ax_box_q    <= 1'b0;
			ax_idx_q    <= '0;
			h_box_q     <= 1'b0;
			h_idx_q     <= '0;
			drain_q     <= '0;
		end else begin
			cmd_q <= '{addr: '0, op: obbf_pkg::OP_NONE};
			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_valid && (slot == obbf_pkg::LAST_SLOT)) begin
						state_q <= ST_CENTER_A;
					end
				end
				ST_CENTER_A: begin
					cmd_q   <= '{addr: obbf_pkg::SLOT_A_CENTER, op: obbf_pkg::OP_LOAD_CA};
					state_q <= ST_CENTER_B;
				end
				ST_CENTER_B: begin
					cmd_q    <= '{addr: obbf_pkg::SLOT_B_CENTER, op: obbf_pkg::OP_LOAD_DIFF};
					ax_box_q <= 1'b0;
					ax_idx_q <= '0;
					state_q  <= ST_AXIS;
				end
				ST_AXIS: begin
					cmd_q   <= '{addr: axis_addr, op: obbf_pkg::OP_LOAD_AXIS};
					h_box_q <= 1'b0;
					h_idx_q <= '0;
					state_q <= ST_DOT;
				end
				ST_DOT: begin
					if (!h_box_q && (h_idx_q == '0)) begin
						cmd_q <= '{addr: half_addr, op: obbf_pkg::OP_DOT_FIRST};
					end else begin
						cmd_q <= '{addr: half_addr, op: obbf_pkg::OP_DOT_NEXT};
					end
					if (h_idx_q == IDX_LAST) begin
						h_idx_q <= '0;
						if (h_box_q) begin
							state_q <= ST_DIFF;
						end else begin
							h_box_q <= 1'b1;
						end
					end else begin
						h_idx_q <= h_idx_q + 2'd1;
					end
				end
				ST_DIFF: begin
					cmd_q <= '{addr: '0, op: obbf_pkg::OP_DOT_DIFF};
					if (ax_idx_q == IDX_LAST) begin
						ax_idx_q <= '0;
						if (ax_box_q) begin
							drain_q <= '0;
							state_q <= ST_DRAIN;
						end else begin
							ax_box_q <= 1'b1;
							state_q  <= ST_AXIS;
						end
					end else begin
						ax_idx_q <= ax_idx_q + 2'd1;
						state_q  <= ST_AXIS;
					end
				end
				ST_DRAIN: begin
					if (drain_q == DRAIN_LAST) begin
						state_q <= ST_FINISH;
					end else begin
						drain_q <= drain_q + 2'd1;
					end
				end
				ST_FINISH: begin
					if (!out_valid_q || out_ready) begin
						hit_q       <= status.act_a && status.act_b && !status.sep;
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;
	assign hit       = hit_q;
	assign cmd       = cmd_q;

endmodule

`default_nettype wire

### rtl/obb_face_axis_overlap_test.sv
// Oriented-box overlap test on the six face axes of two boxes. Each input beat loads one
// vector into a 14-slot store (centers, unit axes and half-extents of boxes A and B); any
// slot other than 13 gives no result, and slots 14 and 15 are dropped.
// A beat on slot 13 starts the test: one shared unit of three multipliers computes one
// exact dot product per cycle, read from the vector store through a three-stage pipeline.
// Two center loads, then for each of the six axes one axis load, seven dot products and one
// compare, and a drain state keep the input closed after the slot 13 beat; the input reopens
// at the edge that raises the result beat, which comes later only while an earlier result beat
// still waits. The result beat carries hit, which is 1 only when both boxes are active and
// no face axis separates them; edge cross-product axes are not tested.
`default_nettype none

module obb_face_axis_overlap_test #(
	parameter int COORD_WIDTH = 24
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_ready,
	input  wire logic [obbf_pkg::SLOT_W-1:0] slot,
	input  wire logic signed [COORD_WIDTH-1:0] vec_x,
	input  wire logic signed [COORD_WIDTH-1:0] vec_y,
	input  wire logic signed [COORD_WIDTH-1:0] vec_z,
	input  wire logic                        box_active,
	output logic                             out_valid,
	input  wire logic                        out_ready,
	output logic                             hit
);

	obbf_pkg::cmd_t    cmd;
	obbf_pkg::status_t status;
	logic              in_fire;

	assign in_fire = in_valid && in_ready;

	obbf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.slot      (slot),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit       (hit),
		.cmd       (cmd),
		.status    (status)
	);

	obbf_dp #(
		.COORD_WIDTH (COORD_WIDTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.wr_en     (in_fire),
		.wr_slot   (slot),
		.wr_x      (vec_x),
		.wr_y      (vec_y),
		.wr_z      (vec_z),
		.wr_active (box_active),
		.cmd       (cmd),
		.status    (status)
	);

endmodule

`default_nettype wire

### sim/obb_face_axis_overlap_test_tb.sv
`timescale 1ns / 1ps

module obb_face_axis_overlap_test_tb;

	localparam int COORD_W     = 24;
	localparam int ONE         = 4096;
	localparam int MAXV        = 8388607;
	localparam int MINV        = -8388608;
	localparam int ITEM_GOAL   = 1340;
	localparam int CALM_ITEMS  = 150;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 100;

	localparam logic [obbf_pkg::SLOT_W-1:0] SLOT_SPARE_LO = 4'd14;
	localparam logic [obbf_pkg::SLOT_W-1:0] SLOT_SPARE_HI = 4'd15;

	class overlap_board;
		logic signed [COORD_W-1:0] vecs [obbf_pkg::SLOT_COUNT][3];
		bit act_a;
		bit act_b;
		bit hits_due[$];
		int errors;

		function new();
			act_a = 0;
			act_b = 0;
			errors = 0;
		endfunction

		function longint abs_dot(int s, longint x, longint y, longint z);
			longint p;
			p = longint'(vecs[s][0]) * x + longint'(vecs[s][1]) * y + longint'(vecs[s][2]) * z;
			return (p < 0) ? -p : p;
		endfunction

		function bit faces_overlap();
			longint d[3];
			longint lhs;
			longint rhs;
			int b, j, k, m, c, ax, hs;
			for (c = 0; c < 3; c++)
				d[c] = longint'(vecs[obbf_pkg::SLOTS_PER_BOX][c]) - longint'(vecs[0][c]);
			for (b = 0; b < 2; b++) begin
				for (j = 0; j < 3; j++) begin
					ax = b * obbf_pkg::SLOTS_PER_BOX + int'(obbf_pkg::SLOT_A_AXIS) + j;
					lhs = 0;
					for (k = 0; k < 2; k++) begin
						for (m = 0; m < 3; m++) begin
							hs = k * obbf_pkg::SLOTS_PER_BOX + int'(obbf_pkg::SLOT_A_HALF) + m;
							lhs += abs_dot(ax, vecs[hs][0], vecs[hs][1], vecs[hs][2]);
						end
					end
					rhs = abs_dot(ax, d[0], d[1], d[2]);
					if (lhs < rhs)
						return 0;
				end
			end
			return 1;
		endfunction

		function void note_beat(logic [obbf_pkg::SLOT_W-1:0] s, logic signed [COORD_W-1:0] x,
				logic signed [COORD_W-1:0] y, logic signed [COORD_W-1:0] z, bit act);
			if (s >= obbf_pkg::SLOT_COUNT)
				return;
			vecs[s][0] = x;
			vecs[s][1] = y;
			vecs[s][2] = z;
			if (s == obbf_pkg::SLOT_A_CENTER)
				act_a = act;
			else if (s == obbf_pkg::SLOT_B_CENTER)
				act_b = act;
			if (s == obbf_pkg::LAST_SLOT)
				hits_due = {hits_due, act_a && act_b && faces_overlap()};
		endfunction

		function void check_hit(bit got);
			bit want;
			if (hits_due.size() == 0) begin
				errors++;
				$display("%0t: unexpected hit beat, expected none, actual %0b", $time, got);
			end else begin
				want = hits_due.pop_front();
				if (want != got) begin
					errors++;
					$display("%0t: hit mismatch, expected %0b, actual %0b", $time, want, got);
				end
			end
		endfunction

		function int pending();
			return hits_due.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [obbf_pkg::SLOT_W-1:0] slot = '0;
	logic signed [COORD_W-1:0] vec_x = '0;
	logic signed [COORD_W-1:0] vec_y = '0;
	logic signed [COORD_W-1:0] vec_z = '0;
	logic box_active = 1'b0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic hit;

	overlap_board sb;
	bit idling_on = 1;
	int n_items = 0;
	int cycle_count = 0;
	int px [obbf_pkg::SLOT_COUNT];
	int py [obbf_pkg::SLOT_COUNT];
	int pz [obbf_pkg::SLOT_COUNT];
	bit pact [2];

	obb_face_axis_overlap_test #(
		.COORD_WIDTH(COORD_W)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.slot(slot),
		.vec_x(vec_x),
		.vec_y(vec_y),
		.vec_z(vec_z),
		.box_active(box_active),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.hit(hit)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("CHECKS FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_hit(hit);
	end

	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (idling_on && $urandom_range(0, 5) == 0) begin
				out_ready = 1'b0;
				repeat ($urandom_range(1, 8)) @(negedge clk);
			end
			out_ready = 1'b1;
		end
	end

	function automatic int srand(int r);
		return int'($urandom_range(0, 2 * r)) - r;
	endfunction

	task automatic send_beat(input logic [obbf_pkg::SLOT_W-1:0] s, input int x, input int y,
			input int z, input bit act);
		in_valid = 1'b1;
		slot = s;
		vec_x = x[COORD_W-1:0];
		vec_y = y[COORD_W-1:0];
		vec_z = z[COORD_W-1:0];
		box_active = act;
		do
			@(posedge clk);
		while (!in_ready);
		sb.note_beat(slot, vec_x, vec_y, vec_z, box_active);
		n_items++;
		@(negedge clk);
		if (idling_on && $urandom_range(0, 3) == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
	endtask

	task automatic send_pair_slot(input int s);
		bit act;
		if (s == obbf_pkg::SLOT_A_CENTER)
			act = pact[0];
		else if (s == obbf_pkg::SLOT_B_CENTER)
			act = pact[1];
		else
			act = 1'($urandom_range(0, 1));
		send_beat(obbf_pkg::SLOT_W'(s), px[s], py[s], pz[s], act);
	endtask

	task automatic drain();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	task automatic make_pair();
		int b, j, rot, base, s, e, spread;
		bit aligned;
		int ax[3];
		spread = $urandom_range(0, 40000);
		for (b = 0; b < 2; b++) begin
			base = b * obbf_pkg::SLOTS_PER_BOX;
			if (b == 0) begin
				px[base] = srand(1 << 20);
				py[base] = srand(1 << 20);
				pz[base] = srand(1 << 20);
			end else begin
				px[base] = px[0] + srand(spread);
				py[base] = py[0] + srand(spread);
				pz[base] = pz[0] + srand(spread);
			end
			pact[b] = ($urandom_range(0, 9) != 0);
			rot = $urandom_range(0, 2);
			aligned = ($urandom_range(0, 3) != 0);
			for (j = 0; j < 3; j++) begin
				if (aligned) begin
					ax = '{0, 0, 0};
					ax[(j + rot) % 3] = $urandom_range(0, 1) ? ONE : -ONE;
				end else begin
					ax = '{srand(ONE), srand(ONE), srand(ONE)};
				end
				s = base + int'(obbf_pkg::SLOT_A_AXIS) + j;
				px[s] = ax[0];
				py[s] = ax[1];
				pz[s] = ax[2];
				e = $urandom_range(256, 4 * ONE);
				s = base + int'(obbf_pkg::SLOT_A_HALF) + j;
				px[s] = int'((longint'(ax[0]) * e) >>> 12);
				py[s] = int'((longint'(ax[1]) * e) >>> 12);
				pz[s] = int'((longint'(ax[2]) * e) >>> 12);
			end
		end
	endtask

	initial begin
		int s, i, j, t, cnt, kind;
		bit mid_drained;
		int order[13];
		sb = new();
		mid_drained = 0;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (s = 0; s < obbf_pkg::SLOT_COUNT; s++) begin
			px[s] = 0;
			py[s] = 0;
			pz[s] = 0;
		end
		for (j = 0; j < 3; j++) begin
			for (i = 0; i < 2; i++) begin
				s = i * obbf_pkg::SLOTS_PER_BOX + int'(obbf_pkg::SLOT_A_AXIS) + j;
				if (j == 0) px[s] = ONE; else if (j == 1) py[s] = ONE; else pz[s] = ONE;
				s = i * obbf_pkg::SLOTS_PER_BOX + int'(obbf_pkg::SLOT_A_HALF) + j;
				if (j == 0) px[s] = ONE; else if (j == 1) py[s] = ONE; else pz[s] = ONE;
			end
		end
		px[obbf_pkg::SLOT_B_CENTER] = ONE;
		pact[0] = 1;
		pact[1] = 1;
		for (s = 0; s < obbf_pkg::SLOT_COUNT; s++)
			send_pair_slot(s);
		send_beat(SLOT_SPARE_LO, $urandom, $urandom, $urandom, 1);
		send_beat(SLOT_SPARE_HI, $urandom, $urandom, $urandom, 0);
		send_beat(obbf_pkg::SLOT_B_CENTER, ONE, 0, 0, 0);
		send_beat(obbf_pkg::LAST_SLOT, 0, 0, ONE, 1);
		send_beat(obbf_pkg::SLOT_B_CENTER, ONE, 0, 0, 1);
		send_beat(obbf_pkg::SLOT_A_AXIS, 0, 0, 0, 1);
		send_beat(obbf_pkg::LAST_SLOT, 0, 0, ONE, 1);
		send_beat(obbf_pkg::SLOT_A_CENTER, MAXV, MAXV, MAXV, 0);
		send_beat(obbf_pkg::LAST_SLOT, MAXV, MINV, MAXV, 0);
		send_beat(obbf_pkg::SLOT_A_CENTER, MAXV, MAXV, MAXV, 1);
		send_beat(obbf_pkg::SLOT_B_CENTER, MINV, MINV, MINV, 1);
		send_beat(obbf_pkg::LAST_SLOT, MINV, MAXV, MINV, 1);
		drain();

		while (n_items < ITEM_GOAL) begin
			if (n_items >= ITEM_GOAL - CALM_ITEMS)
				idling_on = 0;
			if (!mid_drained && n_items >= ITEM_GOAL / 2) begin
				drain();
				mid_drained = 1;
			end
			kind = $urandom_range(0, 9);
			if (kind <= 5) begin
				make_pair();
				for (i = 0; i < 13; i++)
					order[i] = i;
				for (i = 12; i > 0; i--) begin
					j = $urandom_range(0, i);
					t = order[i];
					order[i] = order[j];
					order[j] = t;
				end
				for (i = 0; i < 13; i++) begin
					if ($urandom_range(0, 19) == 0)
						send_beat($urandom_range(0, 1) ? SLOT_SPARE_LO : SLOT_SPARE_HI,
							$urandom, $urandom, $urandom, 1'($urandom_range(0, 1)));
					send_pair_slot(order[i]);
				end
				send_pair_slot(obbf_pkg::LAST_SLOT);
			end else if (kind <= 7) begin
				make_pair();
				cnt = $urandom_range(1, 4);
				repeat (cnt) send_pair_slot($urandom_range(0, 12));
				send_pair_slot(obbf_pkg::LAST_SLOT);
			end else if (kind == 8) begin
				cnt = $urandom_range(1, 4);
				repeat (cnt)
					send_beat(obbf_pkg::SLOT_W'($urandom_range(0, 15)), $urandom, $urandom,
						$urandom, 1'($urandom_range(0, 1)));
			end else begin
				make_pair();
				cnt = $urandom_range(1, 6);
				repeat (cnt) send_pair_slot($urandom_range(0, 12));
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(negedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

endmodule

### files.f
rtl/obbf_pkg.sv
rtl/obbf_dp.sv
rtl/obbf_ctrl.sv
rtl/obb_face_axis_overlap_test.sv
sim/obb_face_axis_overlap_test_tb.sv
